>>> rtl/core/sepm_pkg.sv
// Shared types and constants for the streaming exact pattern matcher.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package sepm_pkg;

	localparam int CHAR_W      = 8;
	localparam int START_W     = 16;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int LEN_REG_W   = 6;
	localparam int PAT_WORDS   = 4;
	localparam int PAT_BYTES   = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_3 = 3'd4;

	typedef logic [PAT_BYTES-1:0][CHAR_W-1:0] pattern_bytes_t;

	// Control handed from the top level to every cell of the window chain
	typedef struct packed {
		logic load;   // a text transaction is taken this cycle
		logic clear;  // it ends the text: empty the window after the compare
	} cell_ctrl_t;

endpackage

>>> rtl/core/sepm_if.sv
// Streaming channels of the pattern matcher: text in, match results out.
// Depends on sepm_pkg for the field widths.
`timescale 1ns / 1ps

interface sepm_text_if;
	logic                       valid;
	logic                       ready;
	logic [sepm_pkg::CHAR_W-1:0] text_char;
	logic                       text_end;

	modport source (output valid, output text_char, output text_end, input ready);
	modport sink   (input valid, input text_char, input text_end, output ready);
endinterface

interface sepm_match_if;
	logic                        valid;
	logic                        ready;
	logic                        match_found;
	logic [sepm_pkg::START_W-1:0] match_start;
	logic                        end_of_text;
	logic                        position_overflow;

	modport source (output valid, output match_found, output match_start,
		output end_of_text, output position_overflow, input ready);
	modport sink   (input valid, input match_found, input match_start,
		input end_of_text, input position_overflow, output ready);
endinterface

>>> rtl/core/streaming_exact_pattern_matcher_top.sv
// Streaming exact pattern matcher: a chain of byte cells holds the text window.
// Pipeline: a taken character passes stage 1, then the output register.
// Throughput: one character per cycle unless match_out stalls; the window shift
// and per-cell compare finish in the accepting cycle, the hit AND at the output.
// Reset: pattern length 1, pattern all zero, window, index count and flag cleared.
// Depends on sepm_pkg, sepm_if and sepm_cell.
`timescale 1ns / 1ps

module streaming_exact_pattern_matcher_top #(
	parameter int MAX_PATTERN = 32,
	parameter int MAX_TEXT    = 65536
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sepm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sepm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	sepm_text_if.sink                          text_in,
	sepm_match_if.source                       match_out
);

	localparam int LW  = $clog2(MAX_PATTERN + 1);
	localparam int LCW = (LW > sepm_pkg::LEN_REG_W) ? LW : sepm_pkg::LEN_REG_W;
	localparam int W   = $clog2(MAX_TEXT);
	localparam int SW0 = (W > LW) ? W + 1 : LW + 1;
	localparam int SW  = (SW0 > sepm_pkg::START_W) ? SW0 : sepm_pkg::START_W;

	logic [sepm_pkg::LEN_REG_W-1:0]                        len_q;
	logic [sepm_pkg::PAT_WORDS-1:0][sepm_pkg::CFG_DATA_W-1:0] pat_words_q;
	sepm_pkg::pattern_bytes_t                              pattern;
	logic [LCW-1:0]                                        len_ext;
	logic [LW-1:0]                                         eff_len;

	logic [W-1:0]  chars_q;
	logic          overflow_q;
	logic          at_limit;
	logic          ovf_next;
	logic          cond;
	logic [SW-1:0] start_full;

	logic          accept;
	logic          out_free;
	logic          adv_s1;
	sepm_pkg::cell_ctrl_t ctrl;

	logic [MAX_PATTERN-1:0][sepm_pkg::CHAR_W-1:0] win;
	logic [MAX_PATTERN-1:0]                       hit_s1;

	logic                          valid_s1;
	logic                          cond_s1;
	logic [sepm_pkg::START_W-1:0]  start_s1;
	logic                          eot_s1;
	logic                          ovf_s1;

	logic                          out_valid_q;
	logic                          found_q;
	logic [sepm_pkg::START_W-1:0]  start_q;
	logic                          eot_q;
	logic                          ovf_out_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= sepm_pkg::LEN_REG_W'(1);
			pat_words_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sepm_pkg::CFG_PATTERN_LENGTH: len_q <= cfg_wdata[sepm_pkg::LEN_REG_W-1:0];
				sepm_pkg::CFG_PATTERN_WORD_0: pat_words_q[0] <= cfg_wdata;
				sepm_pkg::CFG_PATTERN_WORD_1: pat_words_q[1] <= cfg_wdata;
				sepm_pkg::CFG_PATTERN_WORD_2: pat_words_q[2] <= cfg_wdata;
				sepm_pkg::CFG_PATTERN_WORD_3: pat_words_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign pattern = pat_words_q;

	// Length zero acts as one, anything above the window depth as the depth
	always_comb begin
		len_ext = LCW'(len_q);
		if (len_ext == '0) begin
			eff_len = LW'(1);
		end else if (len_ext > LCW'(MAX_PATTERN)) begin
			eff_len = LW'(MAX_PATTERN);
		end else begin
			eff_len = LW'(len_ext);
		end
	end

	// Handshake: stage 1 moves whenever the output register can take its contents
	assign out_free      = !out_valid_q || match_out.ready;
	assign adv_s1        = !valid_s1 || out_free;
	assign text_in.ready = adv_s1;
	assign accept        = text_in.valid && adv_s1;

	assign ctrl.load  = accept;
	assign ctrl.clear = text_in.text_end;

	// Window chain: cell 0 takes the new character, each cell feeds the next
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		logic [sepm_pkg::CHAR_W-1:0] cin;
		if (j == 0) begin : g_head
			assign cin = text_in.text_char;
		end else begin : g_link
			assign cin = win[j-1];
		end
		sepm_cell #(
			.IDX   (j),
			.LEN_W (LW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.eff_len  (eff_len),
			.pattern  (pattern),
			.char_in  (cin),
			.char_out (win[j]),
			.hit_s1   (hit_s1[j])
		);
	end

	// Text index count, saturating
	always_comb begin
		at_limit   = chars_q == W'(MAX_TEXT - 1);
		ovf_next   = at_limit || overflow_q;
		cond       = (SW'(chars_q) + SW'(1)) >= SW'(eff_len);
		start_full = SW'(chars_q) + SW'(1) - SW'(eff_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q    <= '0;
			overflow_q <= 1'b0;
		end else if (accept) begin
			if (text_in.text_end) begin
				chars_q    <= '0;
				overflow_q <= 1'b0;
			end else begin
				overflow_q <= ovf_next;
				if (!at_limit) begin
					chars_q <= chars_q + W'(1);
				end
			end
		end
	end

	// Stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cond_s1  <= cond;
			start_s1 <= cond ? start_full[sepm_pkg::START_W-1:0] : '0;
			eot_s1   <= text_in.text_end;
			ovf_s1   <= ovf_next;
		end
	end

	// Output register: combine the cell hits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			found_q   <= cond_s1 && (&hit_s1);
			start_q   <= (cond_s1 && (&hit_s1)) ? start_s1 : '0;
			eot_q     <= eot_s1;
			ovf_out_q <= ovf_s1;
		end
	end

	assign match_out.valid             = out_valid_q;
	assign match_out.match_found       = found_q;
	assign match_out.match_start       = start_q;
	assign match_out.end_of_text       = eot_q;
	assign match_out.position_overflow = ovf_out_q;

	// Checks
	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && text_in.text_end |=> chars_q == '0 && !overflow_q)
		else $error("end of text did not clear the index count");

	a_ovf_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> chars_q == W'(MAX_TEXT - 1))
		else $error("overflow flag set below the index limit");

	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> start_q == '0)
		else $error("match start nonzero without a match");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!text_in.ready |-> valid_s1 && out_valid_q)
		else $error("input stalled while the pipeline has room");

	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_free |=> out_valid_q)
		else $error("stage 1 result lost on its way to the output");

endmodule

>>> rtl/core/sepm_cell.sv
// One window cell: holds one text byte, passes it to the next cell on every
// transaction and compares the incoming byte against its aligned pattern byte.
// Depends on sepm_pkg.
`timescale 1ns / 1ps

module sepm_cell #(
	parameter int IDX   = 0,
	parameter int LEN_W = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sepm_pkg::cell_ctrl_t          ctrl,
	input  logic [LEN_W-1:0]              eff_len,
	input  sepm_pkg::pattern_bytes_t      pattern,
	input  logic [sepm_pkg::CHAR_W-1:0]   char_in,
	output logic [sepm_pkg::CHAR_W-1:0]   char_out,
	output logic                          hit_s1
);

	localparam int IW = (LEN_W > 6) ? LEN_W : 6;

	logic [IW-1:0]                 pidx;
	logic                          active;
	logic [sepm_pkg::CHAR_W-1:0]   pat_byte;
	logic [sepm_pkg::CHAR_W-1:0]   byte_q;

	// Window position IDX lines up with pattern character eff_len-1-IDX
	always_comb begin
		active = IW'(eff_len) > IW'(IDX);
		pidx   = IW'(eff_len) - IW'(1) - IW'(IDX);
		if (pidx < IW'(sepm_pkg::PAT_BYTES)) begin
			pat_byte = pattern[pidx[4:0]];
		end else begin
			pat_byte = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctrl.load) begin
			byte_q <= ctrl.clear ? '0 : char_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			hit_s1 <= !active || (char_in == pat_byte);
		end
	end

	assign char_out = byte_q;

endmodule

>>> tb/sv/tb_streaming_exact_pattern_matcher_top.sv
// Self-checking testbench for streaming_exact_pattern_matcher_top: drives text, checks matches.
// Depends on sepm_pkg, sepm_if (text and match channels) and the matcher RTL.
`timescale 1ns / 1ps

module tb_streaming_exact_pattern_matcher_top;

	localparam int PATTERN_MAX        = 32;
	localparam int TEXT_MAX           = 65536;
	localparam int WATCHDOG_LIMIT     = 2000;
	localparam int SETTLE_CYCLES      = 8;
	localparam int ITEMS_PER_SETTING  = 85;
	localparam int SETTINGS_PER_PHASE = 4;
	localparam int MAX_REPORTS        = 10;

	typedef struct packed {
		logic                         match_found;
		logic [sepm_pkg::START_W-1:0] match_start;
		logic                         end_of_text;
		logic                         position_overflow;
	} match_rec_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [sepm_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [sepm_pkg::CFG_DATA_W-1:0] cfg_wdata;

	sepm_text_if  text_if();
	sepm_match_if match_if();

	streaming_exact_pattern_matcher_top #(
		.MAX_PATTERN(PATTERN_MAX),
		.MAX_TEXT(TEXT_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.text_in(text_if),
		.match_out(match_if)
	);

	// Matcher state as the block should hold it
	logic [sepm_pkg::LEN_REG_W-1:0]  pat_len_reg;
	logic [sepm_pkg::CFG_DATA_W-1:0] pat_words [sepm_pkg::PAT_WORDS];
	logic [sepm_pkg::CHAR_W-1:0]     window_hist [PATTERN_MAX];
	int unsigned                     text_pos;
	bit                              pos_saturated;

	match_rec_t pending_matches [$];
	int         fail_count;
	int         idle_cycles;
	int         send_idle_pct;
	int         recv_stall_pct;
	logic [sepm_pkg::CHAR_W-1:0] narrow_chars [4] = '{8'h00, 8'hFF, 8'h61, 8'h62};

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int pattern_span();
		if (pat_len_reg == 0)
			return 1;
		if (pat_len_reg > PATTERN_MAX)
			return PATTERN_MAX;
		return int'(pat_len_reg);
	endfunction

	function automatic logic [sepm_pkg::CHAR_W-1:0] pattern_char(input int k);
		return pat_words[k >> 3][(k & 7) * 8 +: 8];
	endfunction

	function automatic void clear_window();
		for (int k = 0; k < PATTERN_MAX; k++)
			window_hist[k] = '0;
		text_pos = 0;
		pos_saturated = 1'b0;
	endfunction

	function automatic match_rec_t predict_match(input logic [sepm_pkg::CHAR_W-1:0] c,
			input logic last);
		match_rec_t r;
		int span;
		bit hit;
		span = pattern_span();
		for (int k = PATTERN_MAX - 1; k > 0; k--)
			window_hist[k] = window_hist[k - 1];
		window_hist[0] = c;
		hit = 1'b0;
		if (text_pos + 1 >= span) begin
			hit = 1'b1;
			for (int k = 0; k < span; k++)
				if (window_hist[span - 1 - k] != pattern_char(k))
					hit = 1'b0;
		end
		r.match_found = hit;
		r.match_start = hit ? sepm_pkg::START_W'(text_pos + 1 - span) : '0;
		// saturate the index, later characters all share the top index
		if (text_pos >= TEXT_MAX - 1) begin
			text_pos = TEXT_MAX - 1;
			pos_saturated = 1'b1;
		end else begin
			text_pos++;
		end
		r.end_of_text = last;
		r.position_overflow = pos_saturated;
		if (last)
			clear_window();
		return r;
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endfunction

	function automatic logic [sepm_pkg::CFG_DATA_W-1:0] random_pattern_word();
		logic [sepm_pkg::CFG_DATA_W-1:0] w;
		if ($urandom_range(1) == 1) begin
			w = {$urandom, $urandom};
		end else begin
			for (int b = 0; b < 8; b++)
				w[b * 8 +: 8] = narrow_chars[$urandom_range(3)];
		end
		return w;
	endfunction

	// Result check first, then the prediction of a newly taken character
	always @(posedge clk) begin
		match_rec_t got;
		match_rec_t want;
		bit moved;
		if (arst_n) begin
			moved = cfg_we;
			if (match_if.valid && match_if.ready) begin
				moved = 1'b1;
				got.match_found = match_if.match_found;
				got.match_start = match_if.match_start;
				got.end_of_text = match_if.end_of_text;
				got.position_overflow = match_if.position_overflow;
				if (pending_matches.size() == 0) begin
					note_failure($sformatf("unexpected result found=%0b start=%0d end=%0b ovf=%0b",
						got.match_found, got.match_start, got.end_of_text,
						got.position_overflow));
				end else begin
					want = pending_matches.pop_front();
					if (got !== want)
						note_failure($sformatf({"result mismatch: expected found=%0b start=%0d ",
							"end=%0b ovf=%0b, got found=%0b start=%0d end=%0b ovf=%0b"},
							want.match_found, want.match_start, want.end_of_text,
							want.position_overflow, got.match_found, got.match_start,
							got.end_of_text, got.position_overflow));
				end
			end
			if (text_if.valid && text_if.ready) begin
				moved = 1'b1;
				pending_matches.push_back(predict_match(text_if.text_char, text_if.text_end));
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL streaming_exact_pattern_matcher_top");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		match_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Entered and left at a falling edge
	task automatic send_char(input logic [sepm_pkg::CHAR_W-1:0] c, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			text_if.valid <= 1'b0;
			@(negedge clk);
		end
		text_if.valid <= 1'b1;
		text_if.text_char <= c;
		text_if.text_end <= last;
		@(posedge clk);
		while (!text_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		text_if.valid <= 1'b0;
		while (pending_matches.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic cfg_put(input logic [sepm_pkg::CFG_IDX_W-1:0] idx,
			input logic [sepm_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			sepm_pkg::CFG_PATTERN_LENGTH: pat_len_reg = data[sepm_pkg::LEN_REG_W-1:0];
			sepm_pkg::CFG_PATTERN_WORD_0: pat_words[0] = data;
			sepm_pkg::CFG_PATTERN_WORD_1: pat_words[1] = data;
			sepm_pkg::CFG_PATTERN_WORD_2: pat_words[2] = data;
			sepm_pkg::CFG_PATTERN_WORD_3: pat_words[3] = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic load_pattern(input logic [sepm_pkg::LEN_REG_W-1:0] len,
			input logic [sepm_pkg::PAT_WORDS-1:0][sepm_pkg::CFG_DATA_W-1:0] words);
		drain();
		cfg_put(sepm_pkg::CFG_PATTERN_LENGTH, sepm_pkg::CFG_DATA_W'(len));
		cfg_put(sepm_pkg::CFG_PATTERN_WORD_0, words[0]);
		cfg_put(sepm_pkg::CFG_PATTERN_WORD_1, words[1]);
		cfg_put(sepm_pkg::CFG_PATTERN_WORD_2, words[2]);
		cfg_put(sepm_pkg::CFG_PATTERN_WORD_3, words[3]);
		cfg_we <= 1'b0;
	endtask

	// Random text with whole pattern copies dropped in; close marks the last character
	task automatic send_text(input int n_chars, input bit close);
		int span;
		int i;
		int pick;
		logic [sepm_pkg::CHAR_W-1:0] c;
		span = pattern_span();
		i = 0;
		while (i < n_chars) begin
			if ($urandom_range(99) < 25 && i + span <= n_chars) begin
				for (int k = 0; k < span; k++) begin
					send_char(pattern_char(k), close && (i == n_chars - 1));
					i++;
				end
			end else begin
				pick = $urandom_range(99);
				if (pick < 45)
					c = pattern_char($urandom_range(span - 1));
				else if (pick < 65)
					c = narrow_chars[$urandom_range(3)];
				else
					c = sepm_pkg::CHAR_W'($urandom_range(255));
				send_char(c, close && (i == n_chars - 1));
				i++;
			end
		end
	endtask

	task automatic test_reset_defaults();
		// pattern is a single zero byte out of reset
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b1);
	endtask

	task automatic test_full_length();
		logic [sepm_pkg::PAT_WORDS-1:0][sepm_pkg::CFG_DATA_W-1:0] w;
		for (int i = 0; i < sepm_pkg::PAT_WORDS; i++)
			w[i] = {$urandom, $urandom};
		w[0][7:0] = 8'h00;
		w[3][63:56] = 8'hFF;
		load_pattern(6'd32, w);
		for (int k = 0; k < PATTERN_MAX; k++)
			send_char(pattern_char(k), k == PATTERN_MAX - 1);
	endtask

	task automatic test_length_clamp();
		// zero length acts as one, oversize acts as the full window
		load_pattern(6'd0, {64'h0, 64'h0, 64'h0, 64'h0000_0000_0000_33A5});
		send_char(8'hA5, 1'b0);
		send_char(8'hA5, 1'b1);
		load_pattern(6'h3F, '0);
		send_char(8'h00, 1'b1);
	endtask

	task automatic test_short_text_zero_bytes();
		load_pattern(6'd4, '0);
		for (int i = 0; i < 3; i++)
			send_char(8'h00, i == 2);
		for (int i = 0; i < 5; i++)
			send_char(8'h00, i == 4);
	endtask

	task automatic test_config_keeps_window();
		load_pattern(6'd2, {64'h0, 64'h0, 64'h0, 64'h0000_0000_0000_0201});
		send_char(8'h10, 1'b0);
		send_char(8'h20, 1'b0);
		load_pattern(6'd3, {64'h0, 64'h0, 64'h0, 64'h0000_0000_0030_2010});
		send_char(8'h30, 1'b1);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct);
		logic [sepm_pkg::PAT_WORDS-1:0][sepm_pkg::CFG_DATA_W-1:0] w;
		logic [sepm_pkg::LEN_REG_W-1:0] len;
		int pick;
		int sent;
		int n;
		drain();
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
			pick = $urandom_range(99);
			if (pick < 10)
				len = '0;
			else if (pick < 60)
				len = sepm_pkg::LEN_REG_W'($urandom_range(1, 8));
			else if (pick < 85)
				len = sepm_pkg::LEN_REG_W'($urandom_range(9, 32));
			else
				len = sepm_pkg::LEN_REG_W'($urandom_range(33, 63));
			for (int i = 0; i < sepm_pkg::PAT_WORDS; i++)
				w[i] = random_pattern_word();
			load_pattern(len, w);
			sent = 0;
			while (sent < ITEMS_PER_SETTING) begin
				n = $urandom_range(1, 2 * pattern_span() + 8);
				// the last text may stay open across the next reconfiguration
				send_text(n, (sent + n < ITEMS_PER_SETTING) ? 1'b1 : 1'($urandom_range(1)));
				sent += n;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = sepm_pkg::CFG_PATTERN_LENGTH;
		cfg_wdata = '0;
		text_if.valid = 1'b0;
		text_if.text_char = '0;
		text_if.text_end = 1'b0;
		match_if.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fail_count = 0;
		idle_cycles = 0;
		pat_len_reg = 1;
		for (int i = 0; i < sepm_pkg::PAT_WORDS; i++)
			pat_words[i] = '0;
		clear_window();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_full_length();
		test_length_clamp();
		test_short_text_zero_bytes();
		test_config_keeps_window();
		test_random_traffic(0, 0);
		test_random_traffic(81, 0);
		test_random_traffic(0, 81);
		test_random_traffic(15, 15);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_matches.size() == 0) begin
			$display("PASS streaming_exact_pattern_matcher_top");
		end else begin
			$display("FAIL streaming_exact_pattern_matcher_top");
		end
		$finish;
	end

endmodule
